[hw/rtl/tcpg_pkg.sv]
// Shared types, symbol codes, tick codes and the BCD helper for the time code generator.
`timescale 1ns / 1ps
`default_nettype none

package tcpg_pkg;

    // Field widths
    localparam int unsigned SecW    = 6;
    localparam int unsigned MinW    = 6;
    localparam int unsigned HourW   = 5;
    localparam int unsigned DayW    = 5;
    localparam int unsigned WdayW   = 3;
    localparam int unsigned MonW    = 4;
    localparam int unsigned YearW   = 7;
    localparam int unsigned SymW    = 2;
    localparam int unsigned TickW   = 4;

    // Symbol codes
    localparam logic [SymW-1:0] SYM_NONE  = 2'd0;
    localparam logic [SymW-1:0] SYM_SHORT = 2'd1;
    localparam logic [SymW-1:0] SYM_LONG  = 2'd2;

    // Tick indexes that act on the carrier, and the last index before it wraps
    localparam logic [TickW-1:0] TICK_START = 4'd0;
    localparam logic [TickW-1:0] TICK_SHORT = 4'd1;
    localparam logic [TickW-1:0] TICK_LONG  = 4'd2;
    localparam logic [TickW-1:0] TICK_LAST  = 4'd9;

    // Second that carries no pulse, and reset mark for the last second seen
    localparam logic [SecW-1:0] SEC_MARKER  = 6'd59;
    localparam logic [SecW-1:0] SEC_NONE    = 6'd63;

    // Result of one tick from the carrier keyer
    typedef struct packed {
        logic            carrier_on;
        logic [SymW-1:0] symbol;
    } t_key_result;

    // Binary to BCD for values up to 99; tens by reciprocal multiply (205/2048)
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'(205);
        tens  = prod[14:11];
        units = v - 7'(tens) * 7'(10);
        return {tens, units[3:0]};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tcpg_frame.sv]
// Minute frame encoder: forms the next minute's frame and picks the current second's symbol.
`timescale 1ns / 1ps
`default_nettype none

module tcpg_frame (
    input  wire logic [tcpg_pkg::SecW-1:0]  i_second,
    input  wire logic [tcpg_pkg::MinW-1:0]  i_minute,
    input  wire logic [tcpg_pkg::HourW-1:0] i_hour,
    input  wire logic [tcpg_pkg::DayW-1:0]  i_day,
    input  wire logic [tcpg_pkg::WdayW-1:0] i_weekday,
    input  wire logic [tcpg_pkg::MonW-1:0]  i_month,
    input  wire logic [tcpg_pkg::YearW-1:0] i_year_of_century,
    input  wire logic                       i_summer_time,
    output logic      [tcpg_pkg::SymW-1:0]  o_symbol
);
    import tcpg_pkg::*;

    logic [6:0]       minute_inc;
    logic             minute_roll;
    logic [6:0]       minute_next;
    logic [5:0]       hour_inc;
    logic [HourW-1:0] hour_next;
    logic [WdayW-1:0] wday_fix;
    logic [6:0]       year_fix;
    logic [7:0]       min_bcd;
    logic [7:0]       hour_bcd;
    logic [7:0]       day_bcd;
    logic [7:0]       wday_bcd;
    logic [7:0]       mon_bcd;
    logic [7:0]       year_bcd;
    logic [63:0]      long_bits;

    // Advance to the next minute, roll the hour, map weekday 0 to 7, fold years of 100 and up
    always_comb begin
        minute_inc  = {1'b0, i_minute} + 7'd1;
        minute_roll = (minute_inc >= 7'd60);
        minute_next = minute_roll ? 7'd0 : minute_inc;
        hour_inc    = {1'b0, i_hour} + 6'd1;
        if (!minute_roll) begin
            hour_next = i_hour;
        end else if (hour_inc >= 6'd24) begin
            hour_next = '0;
        end else begin
            hour_next = hour_inc[HourW-1:0];
        end
        wday_fix = (i_weekday == '0) ? 3'd7 : i_weekday;
        year_fix = (i_year_of_century >= 7'd100) ? (i_year_of_century - 7'd100)
                                                 : i_year_of_century;
    end

    // Code the fields in BCD
    assign min_bcd  = to_bcd(minute_next);
    assign hour_bcd = to_bcd({2'b00, hour_next});
    assign day_bcd  = to_bcd({2'b00, i_day});
    assign wday_bcd = to_bcd({4'b0000, wday_fix});
    assign mon_bcd  = to_bcd({3'b000, i_month});
    assign year_bcd = to_bcd(year_fix);

    // Lay out the long-pulse bits of the frame
    always_comb begin
        long_bits        = '0;
        long_bits[17]    = i_summer_time;
        long_bits[18]    = !i_summer_time;
        long_bits[20]    = 1'b1;
        long_bits[27:21] = min_bcd[6:0];
        long_bits[28]    = ^min_bcd[6:0];
        long_bits[34:29] = hour_bcd[5:0];
        long_bits[35]    = ^hour_bcd[5:0];
        long_bits[41:36] = day_bcd[5:0];
        long_bits[44:42] = wday_bcd[2:0];
        long_bits[49:45] = mon_bcd[4:0];
        long_bits[57:50] = year_bcd;
        long_bits[58]    = ^{day_bcd[5:0], wday_bcd[2:0], mon_bcd[4:0], year_bcd};
    end

    // Pick the symbol of the current second; the marker and out-of-range seconds get none
    always_comb begin
        if (i_second >= SEC_MARKER) begin
            o_symbol = SYM_NONE;
        end else if (long_bits[i_second]) begin
            o_symbol = SYM_LONG;
        end else begin
            o_symbol = SYM_SHORT;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tcpg_keyer.sv]
// Carrier keyer: enable register, last second, tick index and carrier state.
`timescale 1ns / 1ps
`default_nettype none

module tcpg_keyer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic                       i_time_valid,
    input  wire logic [tcpg_pkg::SecW-1:0]  i_second,
    input  wire logic [tcpg_pkg::SymW-1:0]  i_symbol,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_data,
    output tcpg_pkg::t_key_result           o_result,
    output logic                            o_carrier_state
);
    import tcpg_pkg::*;

    logic             r_enable;
    logic [SecW-1:0]  r_prev_sec;
    logic [TickW-1:0] r_tick;
    logic             r_carrier;
    logic [TickW-1:0] n_tick;
    logic             n_carrier;
    logic [TickW-1:0] tick_cur;
    logic             active;

    assign active   = i_time_valid && r_enable;
    assign tick_cur = (i_second != r_prev_sec) ? TICK_START : r_tick;

    // Key the carrier from the tick index within the second
    always_comb begin
        n_tick    = tick_cur + 4'd1;
        n_carrier = r_carrier;
        unique case (tick_cur)
            TICK_START: n_carrier = (i_symbol == SYM_NONE);
            TICK_SHORT: begin
                if (i_symbol == SYM_SHORT) begin
                    n_carrier = 1'b1;
                end
            end
            TICK_LONG:  n_carrier = 1'b1;
            TICK_LAST:  n_tick = TICK_START;
            default:    n_carrier = r_carrier;
        endcase
    end

    // Hold state on ignored ticks, update on active ones; config writes are to come only when idle, not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_prev_sec <= SEC_NONE;
            r_tick     <= TICK_START;
            r_carrier  <= 1'b0;
        end else if (i_cfg_we) begin
            if (r_enable && !i_cfg_data) begin
                r_carrier <= 1'b0;
            end
            if (!r_enable && i_cfg_data) begin
                r_tick <= TICK_START;
            end
            r_enable <= i_cfg_data;
        end else if (i_step && active) begin
            r_prev_sec <= i_second;
            r_tick     <= n_tick;
            r_carrier  <= n_carrier;
        end
    end

    // Report the carrier after this tick and the symbol, or none when ignored
    assign o_result.carrier_on = active ? n_carrier : r_carrier;
    assign o_result.symbol     = active ? i_symbol : SYM_NONE;
    assign o_carrier_state     = r_carrier;

endmodule

`default_nettype wire

[hw/rtl/time_code_pulse_generator_top.sv]
// Top level of the time code pulse generator: input register, encoder, keyer, result register.
//
// Usage: each input item is one 100 ms tick carrying the current wall-clock time.
// The input channel (i_valid / o_stall) accepts an item at a rising edge with
// i_valid high and o_stall low. The result channel (o_valid / i_stall) hands over
// one item per tick with the carrier state and the symbol of the current second.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes transmit_enable;
// it is always ready and is meant to be written while no tick is in flight.
// The input register takes the tick at its accepting edge, and the result register
// loads from it when it is empty or its result is taken; o_valid then offers the result.
// Throughput: one tick per cycle while the receiver does not stall, set by the single
// pass through the frame encoder and keyer between the two registers.
// Reset (synchronous, active low) empties both registers, disables transmission,
// turns the carrier off, clears the tick index and marks no second as seen.
// When the receiver stalls with a result waiting, the input register still takes
// one more tick; o_stall rises only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module time_code_pulse_generator_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_time_valid,
    input  wire logic [tcpg_pkg::SecW-1:0]  i_second,
    input  wire logic [tcpg_pkg::MinW-1:0]  i_minute,
    input  wire logic [tcpg_pkg::HourW-1:0] i_hour,
    input  wire logic [tcpg_pkg::DayW-1:0]  i_day,
    input  wire logic [tcpg_pkg::WdayW-1:0] i_weekday,
    input  wire logic [tcpg_pkg::MonW-1:0]  i_month,
    input  wire logic [tcpg_pkg::YearW-1:0] i_year_of_century,
    input  wire logic                       i_summer_time,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_carrier_on,
    output logic      [tcpg_pkg::SymW-1:0]  o_symbol,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_transmit_enable
);
    import tcpg_pkg::*;

    logic             r_s1_valid;
    logic             r_time_valid;
    logic [SecW-1:0]  r_second;
    logic [MinW-1:0]  r_minute;
    logic [HourW-1:0] r_hour;
    logic [DayW-1:0]  r_day;
    logic [WdayW-1:0] r_weekday;
    logic [MonW-1:0]  r_month;
    logic [YearW-1:0] r_year;
    logic             r_summer;
    logic             r_out_valid;
    t_key_result      r_out;
    logic             advance;
    logic             step;
    logic             cfg_we;
    logic [SymW-1:0]  frame_symbol;
    t_key_result      key_result;
    logic             carrier_state;

    // Pipeline control: the result register moves when empty or taken
    assign advance     = !r_out_valid || !i_stall;
    assign step        = r_s1_valid && advance;
    assign o_stall     = r_s1_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_time_valid <= i_time_valid;
            r_second     <= i_second;
            r_minute     <= i_minute;
            r_hour       <= i_hour;
            r_day        <= i_day;
            r_weekday    <= i_weekday;
            r_month      <= i_month;
            r_year       <= i_year_of_century;
            r_summer     <= i_summer_time;
        end
    end

    tcpg_frame u_frame (
        .i_second          (r_second),
        .i_minute          (r_minute),
        .i_hour            (r_hour),
        .i_day             (r_day),
        .i_weekday         (r_weekday),
        .i_month           (r_month),
        .i_year_of_century (r_year),
        .i_summer_time     (r_summer),
        .o_symbol          (frame_symbol)
    );

    tcpg_keyer u_keyer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_time_valid    (r_time_valid),
        .i_second        (r_second),
        .i_symbol        (frame_symbol),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (i_cfg_transmit_enable),
        .o_result        (key_result),
        .o_carrier_state (carrier_state)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= key_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_carrier_on = r_out.carrier_on;
    assign o_symbol     = r_out.symbol;

    // Checks
    a_symbol_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_symbol == SYM_NONE || o_symbol == SYM_SHORT || o_symbol == SYM_LONG))
        else $error("result symbol outside the code set");

    a_disable_drops_carrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_we && !i_cfg_transmit_enable) |=> !carrier_state)
        else $error("carrier still on after transmit disable");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled while a register is free");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_s1_valid) |=> !o_valid)
        else $error("result appeared without an item in the input register");

endmodule

`default_nettype wire

[test/time_code_pulse_generator_top_test.sv]
// Self-checking testbench for the time code pulse generator: directed table, random ticks.
`timescale 1ns / 1ps

module time_code_pulse_generator_top_test;

    import tcpg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASES = 8;

    // One tick item as it appears on the input ports
    typedef struct packed {
        logic             time_valid;
        logic [SecW-1:0]  second;
        logic [MinW-1:0]  minute;
        logic [HourW-1:0] hour;
        logic [DayW-1:0]  day;
        logic [WdayW-1:0] weekday;
        logic [MonW-1:0]  month;
        logic [YearW-1:0] year_of_century;
        logic             summer_time;
    } t_tick;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    // One row of the directed table: a tick or an enable write
    typedef struct packed {
        t_row_kind   kind;
        logic        enable;
        t_tick       tick;
        logic        typed;
        t_key_result want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_time_valid;
    logic [SecW-1:0]      i_second;
    logic [MinW-1:0]      i_minute;
    logic [HourW-1:0]     i_hour;
    logic [DayW-1:0]      i_day;
    logic [WdayW-1:0]     i_weekday;
    logic [MonW-1:0]      i_month;
    logic [YearW-1:0]     i_year_of_century;
    logic                 i_summer_time;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_carrier_on;
    logic [SymW-1:0]      o_symbol;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_transmit_enable;

    // Shadow of the keyer state and the enable register
    logic                 tx_enable = 1'b0;
    logic [SecW-1:0]      last_second = SEC_NONE;
    logic [TickW-1:0]     tick_pos = TICK_START;
    logic                 carrier = 1'b0;

    t_key_result          key_q[$];
    t_stim_row            dir_rows[25];

    int unsigned          gap_pct = 0;
    int unsigned          stall_pct = 0;
    int unsigned          stall_left = 0;
    int unsigned          err_count = 0;
    int unsigned          tick_count = 0;
    int unsigned          keyed_count = 0;
    int unsigned          result_count = 0;
    int unsigned          write_count = 0;
    int unsigned          cycle_count = 0;

    time_code_pulse_generator_top uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_time_valid          (i_time_valid),
        .i_second              (i_second),
        .i_minute              (i_minute),
        .i_hour                (i_hour),
        .i_day                 (i_day),
        .i_weekday             (i_weekday),
        .i_month               (i_month),
        .i_year_of_century     (i_year_of_century),
        .i_summer_time         (i_summer_time),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_carrier_on          (o_carrier_on),
        .o_symbol              (o_symbol),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_transmit_enable (i_cfg_transmit_enable)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] bcd_of(input int unsigned v);
        return 8'(((v / 10) << 4) + (v % 10));
    endfunction

    // Build the frame of the following minute and pick the symbol of this second
    function automatic logic [SymW-1:0] frame_symbol(input t_tick t);
        int unsigned mins;
        int unsigned hrs;
        int unsigned wd;
        logic [7:0]  min_bcd;
        logic [7:0]  hr_bcd;
        logic [7:0]  day_bcd;
        logic [7:0]  wd_bcd;
        logic [7:0]  mon_bcd;
        logic [7:0]  yr_bcd;
        logic [59:0] longs;
        mins = int'(t.minute) + 1;
        hrs  = int'(t.hour);
        wd   = (t.weekday == '0) ? 7 : int'(t.weekday);
        if (mins >= 60) begin
            mins = 0;
            hrs  = hrs + 1;
            if (hrs >= 24) begin
                hrs = 0;
            end
        end
        min_bcd = bcd_of(mins);
        hr_bcd  = bcd_of(hrs);
        day_bcd = bcd_of(int'(t.day));
        wd_bcd  = bcd_of(wd);
        mon_bcd = bcd_of(int'(t.month));
        yr_bcd  = bcd_of(int'(t.year_of_century) % 100);
        longs = '0;
        longs[17] = t.summer_time;
        longs[18] = !t.summer_time;
        longs[20] = 1'b1;
        longs[27:21] = min_bcd[6:0];
        longs[28] = ^min_bcd[6:0];
        longs[34:29] = hr_bcd[5:0];
        longs[35] = ^hr_bcd[5:0];
        longs[41:36] = day_bcd[5:0];
        longs[44:42] = wd_bcd[2:0];
        longs[49:45] = mon_bcd[4:0];
        longs[57:50] = yr_bcd;
        longs[58] = ^longs[57:36];
        if (t.second >= SEC_MARKER) begin
            return SYM_NONE;
        end
        return longs[t.second] ? SYM_LONG : SYM_SHORT;
    endfunction

    // Advance the keyer shadow by one tick and return the result it gives
    function automatic t_key_result key_step(input t_tick t);
        t_key_result      r;
        logic [TickW-1:0] pos;
        if (!t.time_valid || !tx_enable) begin
            r.carrier_on = carrier;
            r.symbol = SYM_NONE;
            return r;
        end
        r.symbol = frame_symbol(t);
        if (t.second != last_second) begin
            last_second = t.second;
            tick_pos = TICK_START;
        end
        pos = tick_pos;
        tick_pos = tick_pos + 1'b1;
        case (pos)
            TICK_START: carrier = (r.symbol == SYM_NONE);
            TICK_SHORT: begin
                if (r.symbol == SYM_SHORT) begin
                    carrier = 1'b1;
                end
            end
            TICK_LONG:  carrier = 1'b1;
            TICK_LAST:  tick_pos = TICK_START;
            default:    ;
        endcase
        r.carrier_on = carrier;
        return r;
    endfunction

    function automatic t_stim_row tick_row(input logic tv, input int unsigned sec,
                                           input int unsigned mins, input int unsigned hrs,
                                           input int unsigned day, input int unsigned wd,
                                           input int unsigned mon, input int unsigned yr,
                                           input logic dst, input logic typed,
                                           input logic car, input logic [SymW-1:0] sym);
        t_stim_row r;
        r.kind = ROW_TICK;
        r.enable = 1'b0;
        r.tick.time_valid = tv;
        r.tick.second = SecW'(sec);
        r.tick.minute = MinW'(mins);
        r.tick.hour = HourW'(hrs);
        r.tick.day = DayW'(day);
        r.tick.weekday = WdayW'(wd);
        r.tick.month = MonW'(mon);
        r.tick.year_of_century = YearW'(yr);
        r.tick.summer_time = dst;
        r.typed = typed;
        r.want.carrier_on = car;
        r.want.symbol = sym;
        return r;
    endfunction

    function automatic t_stim_row write_row(input logic v);
        t_stim_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.enable = v;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        err_count++;
        if (err_count <= 30) begin
            $display("MISMATCH %0s: expected %0d, got %0d (result %0d)",
                     what, want_v, got_v, result_count);
        end
    endtask

    // Offer one tick, hold it until accepted, then record what it should give
    task automatic send_tick(input t_tick t, input logic typed, input t_key_result want);
        t_key_result predicted;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_time_valid      <= t.time_valid;
        i_second          <= t.second;
        i_minute          <= t.minute;
        i_hour            <= t.hour;
        i_day             <= t.day;
        i_weekday         <= t.weekday;
        i_month           <= t.month;
        i_year_of_century <= t.year_of_century;
        i_summer_time     <= t.summer_time;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tick_count++;
        if (t.time_valid && tx_enable) begin
            keyed_count++;
        end
        predicted = key_step(t);
        key_q.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every pending result is out
    task automatic settle_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (key_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_transmit_enable(input logic v);
        i_cfg_transmit_enable <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (tx_enable && !v) begin
            carrier = 1'b0;
        end
        if (!tx_enable && v) begin
            tick_pos = TICK_START;
        end
        tx_enable = v;
        i_cfg_valid <= 1'b0;
        write_count++;
    endtask

    // Stall the result side in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(11);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin : check_results
        t_key_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (key_q.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 1);
            end else begin
                want = key_q.pop_front();
                if (o_carrier_on !== want.carrier_on) begin
                    report_mismatch("carrier_on", want.carrier_on, o_carrier_on);
                end
                if (o_symbol !== want.symbol) begin
                    report_mismatch("symbol", want.symbol, o_symbol);
                end
            end
            result_count++;
        end
    end

    // Bound the run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("time_code_pulse_generator_top verification failed");
        $finish;
    end

    initial begin
        t_tick       clock_now;
        t_tick       t;
        logic [63:0] noise;
        int unsigned ticks_per;
        int unsigned run_secs;
        int unsigned sent;
        int unsigned target;
        logic        en;

        i_rst_n               <= 1'b0;
        i_valid               <= 1'b0;
        i_time_valid          <= 1'b0;
        i_second              <= '0;
        i_minute              <= '0;
        i_hour                <= '0;
        i_day                 <= '0;
        i_weekday             <= '0;
        i_month               <= '0;
        i_year_of_century     <= '0;
        i_summer_time         <= 1'b0;
        i_cfg_valid           <= 1'b0;
        i_cfg_transmit_enable <= 1'b0;

        // Directed table: disabled after reset, marker, out of range, rollovers, enable edges
        dir_rows[0]  = tick_row(1, 0, 0, 0, 1, 1, 1, 0, 0, 1, 1'b0, SYM_NONE);
        dir_rows[1]  = write_row(1'b1);
        dir_rows[2]  = tick_row(0, 5, 0, 0, 1, 1, 1, 0, 0, 1, 1'b0, SYM_NONE);
        dir_rows[3]  = tick_row(1, 0, 0, 0, 1, 1, 1, 0, 0, 1, 1'b0, SYM_SHORT);
        dir_rows[4]  = tick_row(1, 0, 0, 0, 1, 1, 1, 0, 0, 1, 1'b1, SYM_SHORT);
        dir_rows[5]  = tick_row(1, 59, 0, 0, 1, 1, 1, 0, 0, 1, 1'b1, SYM_NONE);
        dir_rows[6]  = tick_row(1, 63, 0, 0, 1, 1, 1, 0, 0, 1, 1'b1, SYM_NONE);
        dir_rows[7]  = tick_row(1, 20, 0, 0, 1, 1, 1, 0, 0, 1, 1'b0, SYM_LONG);
        dir_rows[8]  = tick_row(1, 20, 0, 0, 1, 1, 1, 0, 0, 1, 1'b0, SYM_LONG);
        dir_rows[9]  = tick_row(1, 20, 0, 0, 1, 1, 1, 0, 0, 1, 1'b1, SYM_LONG);
        dir_rows[10] = tick_row(1, 17, 0, 0, 1, 1, 1, 0, 1, 1, 1'b0, SYM_LONG);
        dir_rows[11] = tick_row(1, 18, 0, 0, 1, 1, 1, 0, 1, 1, 1'b0, SYM_SHORT);
        dir_rows[12] = tick_row(1, 21, 59, 23, 31, 7, 12, 99, 0, 0, 1'b0, SYM_NONE);
        dir_rows[13] = tick_row(1, 29, 63, 31, 1, 1, 1, 0, 1, 0, 1'b0, SYM_NONE);
        dir_rows[14] = tick_row(1, 35, 0, 31, 1, 1, 1, 0, 0, 0, 1'b0, SYM_NONE);
        dir_rows[15] = tick_row(1, 28, 58, 12, 15, 3, 6, 50, 0, 0, 1'b0, SYM_NONE);
        dir_rows[16] = tick_row(1, 42, 10, 10, 10, 0, 10, 10, 1, 0, 1'b0, SYM_NONE);
        dir_rows[17] = tick_row(1, 57, 30, 5, 0, 5, 0, 127, 0, 0, 1'b0, SYM_NONE);
        dir_rows[18] = tick_row(1, 58, 45, 20, 31, 7, 15, 99, 1, 0, 1'b0, SYM_NONE);
        dir_rows[19] = tick_row(1, 45, 1, 1, 1, 1, 12, 1, 0, 0, 1'b0, SYM_NONE);
        dir_rows[20] = write_row(1'b0);
        dir_rows[21] = tick_row(1, 45, 1, 1, 1, 1, 12, 1, 0, 1, 1'b0, SYM_NONE);
        dir_rows[22] = write_row(1'b1);
        dir_rows[23] = tick_row(1, 45, 1, 1, 1, 1, 12, 1, 0, 0, 1'b0, SYM_NONE);
        dir_rows[24] = tick_row(1, 45, 1, 1, 1, 1, 12, 1, 0, 0, 1'b0, SYM_NONE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        gap_pct = 20;
        stall_pct = 20;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                settle_idle();
                write_transmit_enable(dir_rows[r].enable);
            end else begin
                send_tick(dir_rows[r].tick, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // Random phases: mostly running clock sequences, some noise, enable toggled between
        for (int p = 0; p < PHASES; p++) begin
            en = (p % 3 != 2);
            target = en ? 122 : 15;
            if (p == PHASES - 1) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
            end
            settle_idle();
            write_transmit_enable(en);
            sent = 0;
            while (sent < target) begin
                // Start a fresh wall-clock run near the interesting rollovers
                clock_now.time_valid = ($urandom_range(19) != 0);
                clock_now.second = SecW'($urandom_range(59));
                clock_now.minute = ($urandom_range(3) == 0) ? MinW'($urandom_range(57, 59))
                                                            : MinW'($urandom_range(59));
                clock_now.hour = ($urandom_range(3) == 0) ? HourW'(23)
                                                          : HourW'($urandom_range(23));
                clock_now.day = DayW'($urandom_range(1, 31));
                clock_now.weekday = WdayW'($urandom_range(7));
                clock_now.month = MonW'($urandom_range(1, 12));
                clock_now.year_of_century = YearW'($urandom_range(99));
                clock_now.summer_time = 1'($urandom_range(1));
                run_secs = $urandom_range(3, 20);
                for (int s = 0; s < run_secs && sent < target; s++) begin
                    ticks_per = ($urandom_range(4) == 0) ? $urandom_range(1, 12) : 10;
                    for (int k = 0; k < ticks_per && sent < target; k++) begin
                        t = clock_now;
                        if ($urandom_range(99) < 15) begin
                            noise = {$urandom, $urandom};
                            t = noise[$bits(t_tick)-1:0];
                        end
                        send_tick(t, 1'b0, '0);
                        sent++;
                    end
                    // Step the wall clock by one second
                    if (clock_now.second == SecW'(59)) begin
                        clock_now.second = '0;
                        if (clock_now.minute == MinW'(59)) begin
                            clock_now.minute = '0;
                            clock_now.hour = (clock_now.hour == HourW'(23))
                                             ? '0 : clock_now.hour + 1'b1;
                        end else begin
                            clock_now.minute = clock_now.minute + 1'b1;
                        end
                    end else begin
                        clock_now.second = clock_now.second + 1'b1;
                    end
                end
            end
        end

        settle_idle();
        $display("Ran %0d ticks (%0d keyed by an enabled transmitter) and %0d enable writes,",
                 tick_count, keyed_count, write_count);
        $display("checking %0d results against the frame and carrier prediction.",
                 result_count);
        if (err_count == 0) begin
            $display("time_code_pulse_generator_top verification clean");
        end else begin
            $display("time_code_pulse_generator_top verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tcpg_pkg.sv
hw/rtl/tcpg_frame.sv
hw/rtl/tcpg_keyer.sv
hw/rtl/time_code_pulse_generator_top.sv
test/time_code_pulse_generator_top_test.sv
